// File: rtl/rac_pkg.sv
`default_nettype none

package rac_pkg;

  // Default geometry of the region table
  localparam int NUM_REGIONS_DEF = 64;
  localparam int ADDR_WIDTH_DEF  = 64;

  // Fixed field widths at the ports
  localparam int FIELD_ADDR_W = 64;
  localparam int RIGHTS_W     = 3;
  localparam int OUT_IDX_W    = 6;

  // Request codes (code 3 is unused and ignored)
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Result codes
  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_GAP      = 2'd1,
    OUT_BEYOND   = 2'd2,
    OUT_OVERFLOW = 2'd3
  } outcome_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } state_t;

endpackage

`default_nettype wire

// File: rtl/rac_region_mem.sv
`default_nettype none

// Region table storage: one write port, one read port, registered read data.
module rac_region_mem #(
  parameter int  DEPTH = rac_pkg::NUM_REGIONS_DEF,
  parameter int  WIDTH = 2 * rac_pkg::ADDR_WIDTH_DEF + rac_pkg::RIGHTS_W,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [IDX_W-1:0] rd_idx,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and synchronous read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

`default_nettype wire

// File: rtl/region_access_checker_core.sv
`default_nettype none

// Region access checker. Holds up to NUM_REGIONS address regions (inclusive
// start, inclusive end, 3-bit rights) in one synchronous table memory. A load
// word appends a region (or returns an overflow result when the table is
// full); a clear word empties the table and gives no result. A check word
// scans the regions in load order, one table entry per cycle through the
// memory's single read port, and stops at the first region whose start lies
// above the address (gap, denied) or whose end is at or above it (found,
// allowed if the access mask is zero or shares a bit with the rights), or
// after the last loaded region (beyond, denied). A check reads at most as
// many entries as are loaded. One word is processed at a time; a finished
// result sits in the output register while the next word is accepted.
module region_access_checker_core #(
  parameter int NUM_REGIONS = rac_pkg::NUM_REGIONS_DEF,
  parameter int ADDR_WIDTH  = rac_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        req_type,
  input  wire logic [rac_pkg::FIELD_ADDR_W-1:0]  region_start,
  input  wire logic [rac_pkg::FIELD_ADDR_W-1:0]  region_end,
  input  wire logic [rac_pkg::RIGHTS_W-1:0]      region_rights,
  input  wire logic [rac_pkg::FIELD_ADDR_W-1:0]  query_addr,
  input  wire logic [rac_pkg::RIGHTS_W-1:0]      access_mask,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             outcome,
  output logic                                   allowed,
  output logic [rac_pkg::OUT_IDX_W-1:0]          region_index
);

  import rac_pkg::*;

  localparam int IDX_W   = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CNT_W   = $clog2(NUM_REGIONS + 1);
  localparam int ENTRY_W = 2 * ADDR_WIDTH + RIGHTS_W;

  // Sequencer and scan registers
  state_t                state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [ADDR_WIDTH-1:0] addr, addr_next;
  logic [RIGHTS_W-1:0]   mask, mask_next;

  // Pending result
  outcome_t              pend_outcome, pend_outcome_next;
  logic                  pend_allowed, pend_allowed_next;
  logic [OUT_IDX_W-1:0]  pend_index, pend_index_next;
  logic                  out_load;

  // Table port
  logic                  mem_we;
  logic [IDX_W-1:0]      rd_idx;
  logic [ENTRY_W-1:0]    wr_data;
  logic [ENTRY_W-1:0]    rd_data;
  logic [ADDR_WIDTH-1:0] rd_start, rd_end;
  logic [RIGHTS_W-1:0]   rd_rights;
  logic                  last_entry;

  assign wr_data = {region_rights, region_end[ADDR_WIDTH-1:0],
                    region_start[ADDR_WIDTH-1:0]};

  assign rd_start  = rd_data[ADDR_WIDTH-1:0];
  assign rd_end    = rd_data[2*ADDR_WIDTH-1:ADDR_WIDTH];
  assign rd_rights = rd_data[ENTRY_W-1:2*ADDR_WIDTH];

  assign last_entry = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // Loads only happen in idle, so a write never overlaps a scan read
  rac_region_mem #(
    .DEPTH (NUM_REGIONS),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_idx  (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk) begin
    idx          <= idx_next;
    addr         <= addr_next;
    mask         <= mask_next;
    pend_outcome <= pend_outcome_next;
    pend_allowed <= pend_allowed_next;
    pend_index   <= pend_index_next;
  end

  // Next state, table access and result selection
  always_comb begin
    state_next        = state;
    idx_next          = idx;
    count_next        = count;
    addr_next         = addr;
    mask_next         = mask;
    pend_outcome_next = pend_outcome;
    pend_allowed_next = pend_allowed;
    pend_index_next   = pend_index;
    mem_we            = 1'b0;
    rd_idx            = idx;
    out_load          = 1'b0;
    in_ready          = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_t'(req_type))
            REQ_LOAD: begin
              if (count == CNT_W'(NUM_REGIONS)) begin
                pend_outcome_next = OUT_OVERFLOW;
                pend_allowed_next = 1'b0;
                pend_index_next   = '0;
                state_next        = S_EMIT;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            REQ_CHECK: begin
              addr_next = query_addr[ADDR_WIDTH-1:0];
              mask_next = access_mask;
              if (count == '0) begin
                pend_outcome_next = OUT_BEYOND;
                pend_allowed_next = 1'b0;
                pend_index_next   = '0;
                state_next        = S_EMIT;
              end else begin
                idx_next   = '0;
                rd_idx     = '0;
                state_next = S_SCAN;
              end
            end
            REQ_CLEAR: begin
              count_next = '0;
            end
            default: ;
          endcase
        end
      end

      // rd_data holds entry idx
      S_SCAN: begin
        if (addr < rd_start) begin
          pend_outcome_next = OUT_GAP;
          pend_allowed_next = 1'b0;
          pend_index_next   = OUT_IDX_W'(idx);
          state_next        = S_EMIT;
        end else if (addr <= rd_end) begin
          pend_outcome_next = OUT_FOUND;
          pend_allowed_next = (mask == '0) || ((rd_rights & mask) != '0);
          pend_index_next   = OUT_IDX_W'(idx);
          state_next        = S_EMIT;
        end else if (last_entry) begin
          pend_outcome_next = OUT_BEYOND;
          pend_allowed_next = 1'b0;
          pend_index_next   = '0;
          state_next        = S_EMIT;
        end else begin
          idx_next = idx + IDX_W'(1);
          rd_idx   = idx + IDX_W'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      outcome      <= pend_outcome;
      allowed      <= pend_allowed;
      region_index <= pend_index;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_REGIONS))
    else $error("region count above table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> CNT_W'(idx) < count)
    else $error("scan index past loaded regions");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && pend_outcome == OUT_OVERFLOW) |-> count == CNT_W'(NUM_REGIONS))
    else $error("overflow result with table not full");

endmodule

`default_nettype wire

// File: verif/region_access_checker_core_tb.sv
`timescale 1ns / 1ps

module region_access_checker_core_tb;
  import rac_pkg::*;

  // Request code with no meaning; the block drops it
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_REGIONS = NUM_REGIONS_DEF;
  localparam int STIM_WORDS = 1750;
  // Longest scan plus margin
  localparam int DRAIN_CYCLES = 2 * (MAX_REGIONS + 2) + 20;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] rstart;
    logic [63:0] rend;
    logic [2:0]  rights;
    logic [63:0] addr;
    logic [2:0]  mask;
  } req_word_t;

  typedef struct {
    outcome_t   outcome;
    logic       allowed;
    logic [5:0] index;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = 2'd0;
  logic [63:0] region_start = '0;
  logic [63:0] region_end = '0;
  logic [2:0] region_rights = '0;
  logic [63:0] query_addr = '0;
  logic [2:0] access_mask = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic allowed;
  logic [5:0] region_index;

  region_access_checker_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .region_start (region_start),
    .region_end   (region_end),
    .region_rights(region_rights),
    .query_addr   (query_addr),
    .access_mask  (access_mask),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outcome      (outcome),
    .allowed      (allowed),
    .region_index (region_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  req_word_t word_queue[$];
  verdict_t pending_verdicts[$];
  int errors = 0;
  int stim_count = 0;

  // Region table as the block should hold it
  logic [63:0] tbl_start[MAX_REGIONS];
  logic [63:0] tbl_end[MAX_REGIONS];
  logic [2:0]  tbl_rights[MAX_REGIONS];
  int          tbl_count = 0;

  // Apply one accepted word to the table; returns 1 when a verdict is due
  function automatic bit region_verdict(input req_word_t w, output verdict_t v);
    logic [63:0] amask;
    logic [63:0] a;
    bit hit;
    int i;
    amask = {64{1'b1}} >> (64 - ADDR_WIDTH_DEF);
    v = '{OUT_BEYOND, 1'b0, 6'd0};
    region_verdict = 1'b0;
    case (w.kind)
      REQ_LOAD: begin
        if (tbl_count >= MAX_REGIONS) begin
          v = '{OUT_OVERFLOW, 1'b0, 6'd0};
          region_verdict = 1'b1;
        end else begin
          tbl_start[tbl_count] = w.rstart & amask;
          tbl_end[tbl_count] = w.rend & amask;
          tbl_rights[tbl_count] = w.rights;
          tbl_count++;
        end
      end
      REQ_CHECK: begin
        a = w.addr & amask;
        hit = 1'b0;
        region_verdict = 1'b1;
        // First region starting above the address, or ending at or above it
        for (i = 0; i < tbl_count && !hit; i++) begin
          if (a < tbl_start[i]) begin
            v = '{OUT_GAP, 1'b0, i[5:0]};
            hit = 1'b1;
          end else if (a <= tbl_end[i]) begin
            v = '{OUT_FOUND, (w.mask == 3'd0) || ((tbl_rights[i] & w.mask) != 3'd0), i[5:0]};
            hit = 1'b1;
          end
        end
      end
      REQ_CLEAR: tbl_count = 0;
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    rand64 = {$urandom, $urandom};
  endfunction

  task automatic push_word(input logic [1:0] kind, input logic [63:0] rstart,
                           input logic [63:0] rend, input logic [2:0] rights,
                           input logic [63:0] addr, input logic [2:0] mask);
    req_word_t w;
    w = '{kind, rstart, rend, rights, addr, mask};
    word_queue.push_back(w);
    if (kind != REQ_UNUSED) stim_count++;
  endtask

  task automatic push_load(input logic [63:0] rstart, input logic [63:0] rend,
                           input logic [2:0] rights);
    push_word(REQ_LOAD, rstart, rend, rights, rand64(), 3'($urandom_range(0, 7)));
  endtask

  task automatic push_check(input logic [63:0] addr, input logic [2:0] mask);
    push_word(REQ_CHECK, rand64(), rand64(), 3'($urandom_range(0, 7)), addr, mask);
  endtask

  // Driver: bursts of words with random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  req_word_t cur_word;

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (region_verdict(cur_word, v)) pending_verdicts.push_back(v);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          cur_word = word_queue.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_word.kind;
          region_start <= cur_word.rstart;
          region_end <= cur_word.rend;
          region_rights <= cur_word.rights;
          query_addr <= cur_word.addr;
          access_mask <= cur_word.mask;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: phases of always ready, coin flip, mostly stalled, mostly ready
  int stall_phase_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 300);
    end
    stall_phase_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor: compare each result word with the oldest expected verdict
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word outcome=%0d allowed=%0d index=%0d",
                 $time, outcome, allowed, region_index);
      end else begin
        want = pending_verdicts.pop_front();
        if (outcome !== want.outcome) begin
          errors++;
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
        end
        if (allowed !== want.allowed) begin
          errors++;
          $display("%0t: allowed expected %0d actual %0d", $time, want.allowed, allowed);
        end
        if (region_index !== want.index) begin
          errors++;
          $display("%0t: region_index expected %0d actual %0d", $time, want.index,
                   region_index);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [63:0] reg_s[MAX_REGIONS];
    logic [63:0] reg_e[MAX_REGIONS];
    logic [63:0] cur, s, e, gap, len, step_mask, a;
    int n, m, j, k, sel, bits;
    bit first_group;

    // Directed: empty table, edge regions, reversed region, unused code, clear
    push_check(64'd0, 3'd0);
    push_load(64'd0, 64'd0, 3'b000);
    push_load(64'd16, 64'd31, 3'b100);
    push_load(64'd100, 64'd50, 3'b111);
    push_load(64'd200, {64{1'b1}}, 3'b011);
    push_check(64'd0, 3'd0);
    push_check(64'd0, 3'd7);
    push_check(64'd5, 3'd4);
    push_check(64'd16, 3'd4);
    push_check(64'd31, 3'd2);
    push_check(64'd60, 3'd7);
    push_check(64'd150, 3'd1);
    push_check(64'd199, 3'd0);
    push_check({64{1'b1}}, 3'd1);
    push_check(64'd200, 3'd4);
    push_word(REQ_UNUSED, {64{1'b1}}, {64{1'b1}}, 3'd7, {64{1'b1}}, 3'd7);
    push_check(64'd16, 3'd0);
    push_word(REQ_CLEAR, {64{1'b1}}, 64'd0, 3'd7, {64{1'b1}}, 3'd7);
    push_check(64'd0, 3'd0);
    push_load(64'd5, 64'd10, 3'b010);
    push_check(64'd11, 3'd2);
    push_check(64'd10, 3'd2);

    // Random: mostly ordered tables with boundary-heavy checks, some noise
    first_group = 1'b1;
    while (stim_count < STIM_WORDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 85 || first_group) begin
        push_word(REQ_CLEAR, rand64(), rand64(), 3'($urandom_range(0, 7)), rand64(),
                  3'($urandom_range(0, 7)));
        k = $urandom_range(0, 9);
        if (first_group) n = MAX_REGIONS;
        else if (k < 7) n = $urandom_range(1, 8);
        else if (k < 9) n = $urandom_range(9, MAX_REGIONS - 1);
        else n = MAX_REGIONS;
        case ($urandom_range(0, 3))
          0: bits = 4;
          1: bits = 12;
          2: bits = 32;
          default: bits = 60;
        endcase
        step_mask = {64{1'b1}} >> (64 - bits);
        cur = rand64() >> $urandom_range(0, 64);
        for (j = 0; j < n; j++) begin
          gap = rand64() & step_mask;
          len = rand64() & step_mask;
          s = cur + gap;
          if ($urandom_range(0, 19) == 0) begin
            e = s - 64'd1 - (len & 64'hff);
            cur = s + 64'd1;
          end else begin
            e = s + len;
            cur = e + 64'd1;
          end
          reg_s[j] = s;
          reg_e[j] = e;
          push_load(s, e, 3'($urandom_range(0, 7)));
        end
        // Loads into a full table
        if (n == MAX_REGIONS) begin
          m = $urandom_range(1, 3);
          for (j = 0; j < m; j++)
            push_load(rand64(), rand64(), 3'($urandom_range(0, 7)));
        end
        m = $urandom_range(3, 16);
        for (j = 0; j < m; j++) begin
          k = $urandom_range(0, n - 1);
          case ($urandom_range(0, 6))
            0: a = reg_s[k] - 64'd1;
            1: a = reg_s[k];
            2: a = reg_e[k];
            3: a = reg_e[k] + 64'd1;
            4: a = reg_s[k] + ((reg_e[k] - reg_s[k]) >> $urandom_range(1, 63));
            5: a = reg_e[n - 1] + 64'd1 + (rand64() & step_mask);
            default: a = rand64();
          endcase
          push_check(a, 3'($urandom_range(0, 7)));
        end
        first_group = 1'b0;
      end else begin
        push_word(2'($urandom_range(0, 3)), rand64(), rand64(), 3'($urandom_range(0, 7)),
                  rand64(), 3'($urandom_range(0, 7)));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (word_queue.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
